FILE: hw/rtl/wrcs_pkg.sv
// ----------------------------------------------------------------------------
// wrcs_pkg: shared types and constants for the weighted residual engine
// Payload words, register map, sequencer states and fixed-point constants.
// ----------------------------------------------------------------------------
package wrcs_pkg;

   localparam int MAX_POINTS = 65536;
   localparam int IDX_W      = $clog2(MAX_POINTS + 1);
   localparam int WIN_W      = 17;
   localparam int CMP_W      = (IDX_W > WIN_W) ? IDX_W : WIN_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam int MUL_W      = 33;
   localparam int PROD_W     = 2 * MUL_W;

   // ln(2) in Q0.30
   localparam logic [29:0] LN2_Q30 = 30'd744261118;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NOISE_MODE     = 3'd0,
      CSR_USE_ERRORS     = 3'd1,
      CSR_USE_MASK       = 3'd2,
      CSR_WINDOW_START   = 3'd3,
      CSR_WINDOW_END     = 3'd4,
      CSR_WINDOW_END_ENA = 3'd5
   } wrcs_csr_type;

   typedef struct packed {
      logic             noise_mode;
      logic             use_errors;
      logic             use_mask;
      logic [WIN_W-1:0] window_start;
      logic [WIN_W-1:0] window_end;
      logic             window_end_enable;
   } wrcs_cfg_type;

   typedef struct packed {
      logic [31:0] data_count;
      logic [31:0] model_value;
      logic [31:0] error_value;
      logic [16:0] mask_weight;
      logic        last_point;
   } wrcs_req_type;

   typedef struct packed {
      logic signed [31:0] residual;
      logic               has_residual;
      logic [63:0]        sum_of_squares;
      logic [16:0]        point_count;
      logic               misfit_infinite;
      logic               curve_done;
   } wrcs_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SETUP,
      S_DIV,
      S_NORM,
      S_LSQ,
      S_LSQW,
      S_LN,
      S_LNW,
      S_T,
      S_TW,
      S_DEV,
      S_SQRT,
      S_SQRTF,
      S_POST,
      S_MLO,
      S_MLOW,
      S_MHI,
      S_MHIW,
      S_CLAMP,
      S_SQ,
      S_SQW,
      S_FINISH
   } wrcs_state_type;

endpackage

FILE: hw/rtl/weighted_residual_chi_square.sv
// ----------------------------------------------------------------------------
// weighted_residual_chi_square: residual and chi-square engine
// Per data point residual (Neyman or Poisson deviance), mask weighting and a
// saturating sum of squares with an infinite-misfit flag.
// ----------------------------------------------------------------------------
// One word is taken at a time and worked on by a sequencer around a single
// shared 33x33 multiplier; req_ready is low until the result is handed to the
// output register. A point outside the window goes straight to the finish
// state; a Neyman point without errors or with a zero error skips the divide,
// a Neyman point with errors runs a 49-step restoring divide, and a Poisson
// point runs two logarithms of 28 squarings each through the multiplier (plus
// up to 31 normalize steps each) and a 32-step square root; a zero count skips
// the logarithms. A mask adds two passes through the multiplier.
// The result register lets the next word enter while the previous result
// still waits on rsp_ready.
module weighted_residual_chi_square (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  wrcs_pkg::wrcs_req_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output wrcs_pkg::wrcs_rsp_type              rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wrcs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wrcs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   wrcs_pkg::wrcs_cfg_type cfg_ff, cfg_in;
   wrcs_pkg::wrcs_rsp_type rsp_data_ff, rsp_data_in, core_rsp;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   load_ok, core_load;

   assign csr_ready = 1'b1;
   assign load_ok   = !rsp_valid_ff || rsp_ready;

   wrcs_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .start_valid (req_valid),
      .start_ready (req_ready),
      .req         (req_data),
      .load_ok     (load_ok),
      .rsp_load    (core_load),
      .rsp         (core_rsp)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (wrcs_pkg::wrcs_csr_type'(csr_index))
            wrcs_pkg::CSR_NOISE_MODE:     cfg_in.noise_mode        = csr_wdata[0];
            wrcs_pkg::CSR_USE_ERRORS:     cfg_in.use_errors        = csr_wdata[0];
            wrcs_pkg::CSR_USE_MASK:       cfg_in.use_mask          = csr_wdata[0];
            wrcs_pkg::CSR_WINDOW_START:   cfg_in.window_start      = csr_wdata;
            wrcs_pkg::CSR_WINDOW_END:     cfg_in.window_end        = csr_wdata;
            wrcs_pkg::CSR_WINDOW_END_ENA: cfg_in.window_end_enable = csr_wdata[0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (core_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.noise_mode        <= 1'b0;
         cfg_ff.use_errors        <= 1'b0;
         cfg_ff.use_mask          <= 1'b0;
         cfg_ff.window_start      <= '0;
         cfg_ff.window_end        <= 17'h10000;
         cfg_ff.window_end_enable <= 1'b0;
         rsp_valid_ff             <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hw/rtl/wrcs_mul.sv
// ----------------------------------------------------------------------------
// wrcs_mul: shared unsigned multiplier
// 33 x 33 bit product, registered; result is valid in the cycle after the operands.
// ----------------------------------------------------------------------------
module wrcs_mul (
   input  logic                         clock,
   input  logic [wrcs_pkg::MUL_W-1:0]   mul_a,
   input  logic [wrcs_pkg::MUL_W-1:0]   mul_b,
   output logic [wrcs_pkg::PROD_W-1:0]  mul_p
);

   logic [wrcs_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= wrcs_pkg::PROD_W'(mul_a) * wrcs_pkg::PROD_W'(mul_b);
   end

   assign mul_p = prod_ff;

endmodule

FILE: hw/rtl/wrcs_core.sv
// ----------------------------------------------------------------------------
// wrcs_core: sequencer and datapath for one data point
// Restoring divide, log2 by repeated squaring, bitwise square root, mask
// scaling and chi-square accumulation; squarings, scaling and squares share one multiplier.
// ----------------------------------------------------------------------------
module wrcs_core (
   input  logic                   clock,
   input  logic                   reset,
   input  wrcs_pkg::wrcs_cfg_type cfg,
   input  logic                   start_valid,
   output logic                   start_ready,
   input  wrcs_pkg::wrcs_req_type req,
   input  logic                   load_ok,
   output logic                   rsp_load,
   output wrcs_pkg::wrcs_rsp_type rsp
);

   wrcs_pkg::wrcs_state_type state_ff, state_in;

   logic [31:0] y_ff, y_in, mu_ff, mu_in, e_ff, e_in;
   logic [16:0] w_ff, w_in;
   logic        last_ff, last_in, inside_ff, inside_in, neg_ff, neg_in;
   logic        zdiv_ff, zdiv_in, lge_ff, lge_in, which_ff, which_in;
   logic [63:0] mag_ff, mag_in, acc_ff, acc_in, bit_ff, bit_in;
   logic [31:0] rem_ff, rem_in, m_ff, m_in, lnq_ff, lnq_in;
   logic [4:0]  k_ff, k_in;
   logic [27:0] frac_ff, frac_in;
   logic [32:0] ly_ff, ly_in;
   logic [5:0]  cnt_ff, cnt_in;

   logic [wrcs_pkg::IDX_W-1:0] point_index_ff, point_index_in;
   logic [wrcs_pkg::IDX_W-1:0] residual_total_ff, residual_total_in;
   logic [63:0]                square_sum_ff, square_sum_in;
   logic                       inf_ff, inf_in;

   logic [wrcs_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic [wrcs_pkg::PROD_W-1:0] mul_p;

   wrcs_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= wrcs_pkg::S_IDLE;
         point_index_ff    <= '0;
         residual_total_ff <= '0;
         square_sum_ff     <= '0;
         inf_ff            <= 1'b0;
      end else begin
         state_ff          <= state_in;
         point_index_ff    <= point_index_in;
         residual_total_ff <= residual_total_in;
         square_sum_ff     <= square_sum_in;
         inf_ff            <= inf_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff      <= y_in;
      mu_ff     <= mu_in;
      e_ff      <= e_in;
      w_ff      <= w_in;
      last_ff   <= last_in;
      inside_ff <= inside_in;
      neg_ff    <= neg_in;
      zdiv_ff   <= zdiv_in;
      lge_ff    <= lge_in;
      which_ff  <= which_in;
      mag_ff    <= mag_in;
      acc_ff    <= acc_in;
      bit_ff    <= bit_in;
      rem_ff    <= rem_in;
      m_ff      <= m_in;
      lnq_ff    <= lnq_in;
      k_ff      <= k_in;
      frac_ff   <= frac_in;
      ly_ff     <= ly_in;
      cnt_ff    <= cnt_in;
   end

   logic [63:0] limit;
   assign limit = neg_ff ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;

   always_comb begin
      logic [32:0]  rem_sh;
      logic [32:0]  sq_s;
      logic [27:0]  frac_nx;
      logic [32:0]  lm_v;
      logic [32:0]  a_v;
      logic [65:0]  rnd;
      logic [63:0]  dev_v;
      logic [63:0]  trial;
      logic [64:0]  sum65;
      logic [31:0]  diff;
      logic [65:0]  mix;

      state_in          = state_ff;
      y_in              = y_ff;
      mu_in             = mu_ff;
      e_in              = e_ff;
      w_in              = w_ff;
      last_in           = last_ff;
      inside_in         = inside_ff;
      neg_in            = neg_ff;
      zdiv_in           = zdiv_ff;
      lge_in            = lge_ff;
      which_in          = which_ff;
      mag_in            = mag_ff;
      acc_in            = acc_ff;
      bit_in            = bit_ff;
      rem_in            = rem_ff;
      m_in              = m_ff;
      lnq_in            = lnq_ff;
      k_in              = k_ff;
      frac_in           = frac_ff;
      ly_in             = ly_ff;
      cnt_in            = cnt_ff;
      point_index_in    = point_index_ff;
      residual_total_in = residual_total_ff;
      square_sum_in     = square_sum_ff;
      inf_in            = inf_ff;
      mul_a             = '0;
      mul_b             = '0;
      start_ready       = 1'b0;
      rsp_load          = 1'b0;
      rem_sh            = '0;
      sq_s              = '0;
      frac_nx           = '0;
      lm_v              = '0;
      a_v               = '0;
      rnd               = '0;
      dev_v             = '0;
      trial             = '0;
      sum65             = '0;
      diff              = '0;
      mix               = '0;

      case (state_ff)
         wrcs_pkg::S_IDLE: begin
            start_ready = 1'b1;
            if (start_valid) begin
               y_in    = req.data_count;
               mu_in   = (cfg.noise_mode && req.model_value == 32'd0) ? 32'd1
                                                                    : req.model_value;
               e_in    = req.error_value;
               w_in    = (req.mask_weight > 17'h10000) ? 17'h10000 : req.mask_weight;
               last_in = req.last_point;
               inside_in = (wrcs_pkg::CMP_W'(point_index_ff) >=
                            wrcs_pkg::CMP_W'(cfg.window_start)) &&
                           (!cfg.window_end_enable ||
                            wrcs_pkg::CMP_W'(point_index_ff) <
                            wrcs_pkg::CMP_W'(cfg.window_end));
               neg_in   = 1'b0;
               zdiv_in  = 1'b0;
               mag_in   = '0;
               state_in = wrcs_pkg::S_SETUP;
            end
         end

         wrcs_pkg::S_SETUP: begin
            if (!inside_ff) begin
               state_in = wrcs_pkg::S_FINISH;
            end else if (cfg.noise_mode) begin
               neg_in = y_ff > mu_ff;
               if (y_ff == 32'd0) begin
                  // y ln(y/mu) term vanishes
                  acc_in   = '0;
                  lge_in   = 1'b1;
                  state_in = wrcs_pkg::S_DEV;
               end else begin
                  m_in     = y_ff;
                  k_in     = 5'd31;
                  frac_in  = '0;
                  cnt_in   = '0;
                  which_in = 1'b0;
                  state_in = wrcs_pkg::S_NORM;
               end
            end else begin
               neg_in = mu_ff > y_ff;
               diff   = (mu_ff > y_ff) ? (mu_ff - y_ff) : (y_ff - mu_ff);
               if (cfg.use_errors) begin
                  if (e_ff == 32'd0) begin
                     zdiv_in  = 1'b1;
                     mag_in   = 64'(diff);
                     state_in = wrcs_pkg::S_POST;
                  end else begin
                     // dividend carries the rounding offset, up to 49 bits
                     mag_in   = 64'({diff, 16'h0000}) + 64'(e_ff[31:1]);
                     rem_in   = '0;
                     cnt_in   = '0;
                     state_in = wrcs_pkg::S_DIV;
                  end
               end else begin
                  mag_in   = 64'(diff);
                  state_in = wrcs_pkg::S_POST;
               end
            end
         end

         wrcs_pkg::S_DIV: begin
            rem_sh = {rem_ff, mag_ff[48]};
            if (rem_sh >= {1'b0, e_ff}) begin
               rem_in = 32'(rem_sh - {1'b0, e_ff});
               mag_in = {15'h0, mag_ff[47:0], 1'b1};
            end else begin
               rem_in = rem_sh[31:0];
               mag_in = {15'h0, mag_ff[47:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd48) begin
               state_in = wrcs_pkg::S_POST;
            end
         end

         wrcs_pkg::S_NORM: begin
            if (!m_ff[31] && k_ff != 5'd0) begin
               m_in = {m_ff[30:0], 1'b0};
               k_in = k_ff - 5'd1;
            end else begin
               cnt_in   = '0;
               state_in = wrcs_pkg::S_LSQ;
            end
         end

         wrcs_pkg::S_LSQ: begin
            mul_a    = {1'b0, m_ff};
            mul_b    = {1'b0, m_ff};
            state_in = wrcs_pkg::S_LSQW;
         end

         wrcs_pkg::S_LSQW: begin
            sq_s    = mul_p[63:31];
            frac_nx = {frac_ff[26:0], sq_s[32]};
            m_in    = sq_s[32] ? sq_s[32:1] : sq_s[31:0];
            frac_in = frac_nx;
            if (cnt_ff == 6'd27) begin
               if (!which_ff) begin
                  ly_in    = {k_ff, frac_nx};
                  m_in     = mu_ff;
                  k_in     = 5'd31;
                  frac_in  = '0;
                  which_in = 1'b1;
                  state_in = wrcs_pkg::S_NORM;
               end else begin
                  state_in = wrcs_pkg::S_LN;
               end
            end else begin
               cnt_in   = cnt_ff + 6'd1;
               state_in = wrcs_pkg::S_LSQ;
            end
         end

         wrcs_pkg::S_LN: begin
            lm_v     = {k_ff, frac_ff};
            lge_in   = ly_ff >= lm_v;
            a_v      = (ly_ff >= lm_v) ? (ly_ff - lm_v) : (lm_v - ly_ff);
            mul_a    = a_v;
            mul_b    = wrcs_pkg::MUL_W'(wrcs_pkg::LN2_Q30);
            state_in = wrcs_pkg::S_LNW;
         end

         wrcs_pkg::S_LNW: begin
            rnd      = mul_p + (66'd1 << 33);
            lnq_in   = 32'(rnd >> 34);
            state_in = wrcs_pkg::S_T;
         end

         wrcs_pkg::S_T: begin
            mul_a    = {1'b0, y_ff};
            mul_b    = {1'b0, lnq_ff};
            state_in = wrcs_pkg::S_TW;
         end

         wrcs_pkg::S_TW: begin
            rnd      = mul_p + 66'd128;
            acc_in   = 64'(rnd >> 8);
            state_in = wrcs_pkg::S_DEV;
         end

         wrcs_pkg::S_DEV: begin
            // 2 * ((mu - y) * 2^16 +/- y ln(y/mu)), two's complement
            dev_v = (64'(mu_ff) << 16) - (64'(y_ff) << 16);
            dev_v = lge_ff ? (dev_v + acc_ff) : (dev_v - acc_ff);
            dev_v = {dev_v[62:0], 1'b0};
            mag_in = '0;
            if ($signed(dev_v) <= 64'sd0) begin
               state_in = wrcs_pkg::S_POST;
            end else begin
               acc_in   = dev_v;
               bit_in   = 64'd1 << 62;
               cnt_in   = '0;
               state_in = wrcs_pkg::S_SQRT;
            end
         end

         wrcs_pkg::S_SQRT: begin
            trial = mag_ff + bit_ff;
            if (acc_ff >= trial) begin
               acc_in = acc_ff - trial;
               mag_in = (mag_ff >> 1) + bit_ff;
            end else begin
               mag_in = mag_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               state_in = wrcs_pkg::S_SQRTF;
            end
         end

         wrcs_pkg::S_SQRTF: begin
            if (acc_ff > mag_ff) begin
               mag_in = mag_ff + 64'd1;
            end
            state_in = wrcs_pkg::S_POST;
         end

         wrcs_pkg::S_POST: begin
            if (zdiv_ff) begin
               inf_in   = 1'b1;
               mag_in   = (mag_ff != 64'd0) ? limit : 64'd0;
               state_in = wrcs_pkg::S_SQ;
            end else if (cfg.use_mask) begin
               state_in = wrcs_pkg::S_MLO;
            end else begin
               state_in = wrcs_pkg::S_CLAMP;
            end
         end

         wrcs_pkg::S_MLO: begin
            mul_a    = {1'b0, mag_ff[31:0]};
            mul_b    = wrcs_pkg::MUL_W'(w_ff);
            state_in = wrcs_pkg::S_MLOW;
         end

         wrcs_pkg::S_MLOW: begin
            acc_in   = mul_p[63:0];
            state_in = wrcs_pkg::S_MHI;
         end

         wrcs_pkg::S_MHI: begin
            mul_a    = wrcs_pkg::MUL_W'(mag_ff[47:32]);
            mul_b    = wrcs_pkg::MUL_W'(w_ff);
            state_in = wrcs_pkg::S_MHIW;
         end

         wrcs_pkg::S_MHIW: begin
            mix      = {mul_p[33:0], 32'h0000_0000} + 66'(acc_ff) + 66'd32768;
            mag_in   = 64'(mix >> 16);
            state_in = wrcs_pkg::S_CLAMP;
         end

         wrcs_pkg::S_CLAMP: begin
            if (mag_ff > limit) begin
               mag_in = limit;
               inf_in = 1'b1;
            end
            state_in = wrcs_pkg::S_SQ;
         end

         wrcs_pkg::S_SQ: begin
            mul_a    = {1'b0, mag_ff[31:0]};
            mul_b    = {1'b0, mag_ff[31:0]};
            state_in = wrcs_pkg::S_SQW;
         end

         wrcs_pkg::S_SQW: begin
            sum65 = {1'b0, square_sum_ff} + {1'b0, mul_p[63:0]};
            if (sum65[64]) begin
               square_sum_in = '1;
               inf_in        = 1'b1;
            end else begin
               square_sum_in = sum65[63:0];
            end
            if (residual_total_ff < wrcs_pkg::IDX_W'(wrcs_pkg::MAX_POINTS)) begin
               residual_total_in = residual_total_ff + 1'b1;
            end
            state_in = wrcs_pkg::S_FINISH;
         end

         wrcs_pkg::S_FINISH: begin
            rsp_load = load_ok;
            if (load_ok) begin
               if (point_index_ff < wrcs_pkg::IDX_W'(wrcs_pkg::MAX_POINTS)) begin
                  point_index_in = point_index_ff + 1'b1;
               end
               if (last_ff) begin
                  point_index_in    = '0;
                  residual_total_in = '0;
                  square_sum_in     = '0;
                  inf_in            = 1'b0;
               end
               state_in = wrcs_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = wrcs_pkg::S_IDLE;
         end
      endcase
   end

   // result word, taken before the end-of-curve clear
   always_comb begin
      rsp.residual        = neg_ff ? $signed(32'd0 - mag_ff[31:0]) : $signed(mag_ff[31:0]);
      rsp.has_residual    = inside_ff;
      rsp.sum_of_squares  = inf_ff ? 64'hFFFF_FFFF_FFFF_FFFF : square_sum_ff;
      rsp.point_count     = 17'(residual_total_ff);
      rsp.misfit_infinite = inf_ff;
      rsp.curve_done      = last_ff;
   end

`ifndef SYNTHESIS
   a_square_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wrcs_pkg::S_SQ) |-> (mag_ff <= 64'h0000_0000_8000_0000))
      else $error("magnitude above limit at squaring");

   a_curve_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && last_ff) |=> (point_index_ff == '0 && square_sum_ff == '0 && !inf_ff))
      else $error("curve state not cleared after last point");

   a_flag_sticky: assert property (@(posedge clock) disable iff (reset)
      (inf_ff && !(rsp_load && last_ff)) |=> inf_ff)
      else $error("infinite-misfit flag dropped inside a curve");

   a_out_window_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wrcs_pkg::S_FINISH && !inside_ff) |-> (rsp.residual == 32'sd0))
      else $error("residual produced outside the window");
`endif

endmodule

FILE: bench/weighted_residual_chi_square_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weighted_residual_chi_square_tb: self-checking bench for the residual engine
// Directed and random data points under several window, noise and mask
// settings; every result word is checked against a local predictor.
// ----------------------------------------------------------------------------
module weighted_residual_chi_square_tb;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   wrcs_pkg::wrcs_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   wrcs_pkg::wrcs_rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [wrcs_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [wrcs_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   weighted_residual_chi_square u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor copy of the configuration and curve state
   logic        p_noise, p_err, p_mask, p_wend_en;
   logic [16:0] p_wstart, p_wend;
   int unsigned p_index, p_total;
   logic [63:0] p_sum;
   logic        p_inf;

   wrcs_pkg::wrcs_req_type point_q[$];
   wrcs_pkg::wrcs_rsp_type expected_q[$];
   int  errors = 0;
   bit  hold_rsp = 0;
   int  hold_cnt = 0;
   int  idle_cycles = 0;

   function automatic logic [63:0] log2_fixed(logic [31:0] v);
      int k;
      logic [63:0] m, frac;
      k = 31;
      frac = 0;
      while (k > 0 && v[k] == 1'b0) k--;
      m = 64'(v) << (31 - k);
      for (int i = 0; i < 28; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            m = m >> 1;
            frac[0] = 1'b1;
         end
      end
      return (64'(k) << 28) | frac;
   endfunction

   function automatic logic [63:0] sqrt_nearest(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      if (v > r) r++;
      return r;
   endfunction

   function automatic logic [63:0] deviance_mag(logic [31:0] y, logic [31:0] mu);
      logic signed [63:0] dev;
      logic [63:0] ly, lm, a, lnq, t;
      dev = (64'(signed'({1'b0, mu})) - 64'(signed'({1'b0, y}))) * 65536;
      if (y != 0) begin
         ly = log2_fixed(y);
         lm = log2_fixed(mu);
         a = (ly >= lm) ? ly - lm : lm - ly;
         lnq = (a * 64'd744261118 + (64'd1 << 33)) >> 34;
         t = (64'(y) * lnq + 64'd128) >> 8;
         if (ly >= lm) dev = dev + signed'(t);
         else dev = dev - signed'(t);
      end
      dev = dev * 2;
      if (dev <= 0) return 0;
      return sqrt_nearest(dev);
   endfunction

   function automatic wrcs_pkg::wrcs_rsp_type predict_residual(wrcs_pkg::wrcs_req_type p);
      wrcs_pkg::wrcs_rsp_type r;
      logic in_win, neg, zdiv;
      logic [63:0] mag, lim, sq, w;
      logic [31:0] muf;
      r = '0;
      zdiv = 0;
      in_win = p_index >= p_wstart && (!p_wend_en || p_index < p_wend);
      if (in_win) begin
         if (p_noise) begin
            muf = (p.model_value != 0) ? p.model_value : 32'd1;
            neg = p.data_count > muf;
            mag = deviance_mag(p.data_count, muf);
         end else begin
            neg = p.model_value > p.data_count;
            mag = neg ? 64'(p.model_value - p.data_count)
                      : 64'(p.data_count - p.model_value);
            if (p_err) begin
               if (p.error_value == 0) zdiv = 1;
               else mag = ((mag << 16) + 64'(p.error_value >> 1)) / 64'(p.error_value);
            end
         end
         lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
         if (zdiv) begin
            p_inf = 1;
            if (mag != 0) mag = lim;
         end else begin
            if (p_mask) begin
               w = (p.mask_weight > 17'd65536) ? 64'd65536 : 64'(p.mask_weight);
               mag = (mag * w + 64'd32768) >> 16;
            end
            if (mag > lim) begin
               mag = lim;
               p_inf = 1;
            end
         end
         r.residual = neg ? 32'(0 - mag[31:0]) : mag[31:0];
         sq = mag * mag;
         if (p_sum > ~64'd0 - sq) begin
            p_sum = ~64'd0;
            p_inf = 1;
         end else begin
            p_sum = p_sum + sq;
         end
         if (p_total < wrcs_pkg::MAX_POINTS) p_total++;
      end
      if (p_index < wrcs_pkg::MAX_POINTS) p_index++;
      r.has_residual = in_win;
      r.sum_of_squares = p_inf ? ~64'd0 : p_sum;
      r.point_count = p_total[16:0];
      r.misfit_infinite = p_inf;
      r.curve_done = p.last_point;
      if (p.last_point) begin
         p_index = 0;
         p_total = 0;
         p_sum = 0;
         p_inf = 0;
      end
      return r;
   endfunction

   // driver: predicts at acceptance so config changes stay in order
   int gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_q.push_back(predict_residual(req_data));
            void'(point_q.pop_front());
         end
         if (!(req_valid && !req_ready)) begin
            if (gap > 0) begin
               gap <= gap - 1;
               req_valid <= 1'b0;
            end else if (point_q.size() != 0) begin
               req_valid <= 1'b1;
               req_data <= point_q[0];
               gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
                                                  : $urandom_range(0, 2);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   int rsp_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, rsp_data);
               errors++;
            end else begin
               wrcs_pkg::wrcs_rsp_type e;
               e = expected_q.pop_front();
               if (e.residual !== rsp_data.residual)
                  $display("%0t: residual exp %h got %h", $time, e.residual, rsp_data.residual);
               if (e.has_residual !== rsp_data.has_residual)
                  $display("%0t: has_residual exp %b got %b", $time, e.has_residual,
                           rsp_data.has_residual);
               if (e.sum_of_squares !== rsp_data.sum_of_squares)
                  $display("%0t: sum_of_squares exp %h got %h", $time, e.sum_of_squares,
                           rsp_data.sum_of_squares);
               if (e.point_count !== rsp_data.point_count)
                  $display("%0t: point_count exp %0d got %0d", $time, e.point_count,
                           rsp_data.point_count);
               if (e.misfit_infinite !== rsp_data.misfit_infinite)
                  $display("%0t: misfit_infinite exp %b got %b", $time, e.misfit_infinite,
                           rsp_data.misfit_infinite);
               if (e.curve_done !== rsp_data.curve_done)
                  $display("%0t: curve_done exp %b got %b", $time, e.curve_done,
                           rsp_data.curve_done);
               if (e !== rsp_data) errors++;
            end
         end
         // long hold-off, counted here
         if (hold_rsp && hold_cnt < 400) begin
            hold_cnt <= hold_cnt + 1;
            rsp_ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
               rsp_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
                                                      : $urandom_range(0, 2);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || hold_rsp)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("weighted_residual_chi_square_tb NOT OK");
         $finish;
      end
   end

   task automatic csr_write(wrcs_pkg::wrcs_csr_type idx, logic [16:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         wrcs_pkg::CSR_NOISE_MODE:     p_noise = val[0];
         wrcs_pkg::CSR_USE_ERRORS:     p_err = val[0];
         wrcs_pkg::CSR_USE_MASK:       p_mask = val[0];
         wrcs_pkg::CSR_WINDOW_START:   p_wstart = val;
         wrcs_pkg::CSR_WINDOW_END:     p_wend = val;
         wrcs_pkg::CSR_WINDOW_END_ENA: p_wend_en = val[0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (point_q.size() != 0 || req_valid || expected_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic push_point(logic [31:0] y, logic [31:0] mu, logic [31:0] e,
                             logic [16:0] m, logic last);
      wrcs_pkg::wrcs_req_type p;
      p.data_count = y;
      p.model_value = mu;
      p.error_value = e;
      p.mask_weight = m;
      p.last_point = last;
      point_q.push_back(p);
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $urandom_range(0, 16);
         2: return $urandom_range(0, 32'h00FF_FFFF);
         default: return $urandom_range(32'h0001_0000, 32'h0100_0000);
      endcase
   endfunction

   task automatic random_curves(int n);
      for (int i = 0; i < n; i++) begin
         logic [31:0] y, mu;
         y = rand_value();
         mu = ($urandom_range(0, 3) == 0) ? rand_value() : y + $urandom_range(0, 32'h3_0000)
              - 32'h1_8000;
         push_point(y, mu, ($urandom_range(0, 19) == 0) ? 32'd0 : rand_value(),
                    ($urandom_range(0, 7) == 0) ? 17'(~0) : 17'($urandom_range(0, 65536)),
                    ($urandom_range(0, 11) == 0) || i == n - 1);
      end
   endtask

   initial begin
      p_noise = 0; p_err = 0; p_mask = 0; p_wend_en = 0;
      p_wstart = 0; p_wend = 17'd65536;
      p_index = 0; p_total = 0; p_sum = 0; p_inf = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes in Neyman, with and without errors
      csr_write(wrcs_pkg::CSR_USE_ERRORS, 1);
      push_point(32'hFFFF_FFFF, 0, 1, 0, 0);
      push_point(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'h1FFFF, 0);
      push_point(5, 3, 0, 0, 0);
      push_point(7, 7, 0, 0, 0);
      push_point(3, 9, 0, 0, 0);
      push_point(32'h0002_0000, 32'h0001_0000, 32'h0000_8000, 65536, 1);
      drain();
      csr_write(wrcs_pkg::CSR_USE_ERRORS, 0);
      csr_write(wrcs_pkg::CSR_USE_MASK, 1);
      push_point(32'hFFFF_FFFF, 0, 0, 65536, 0);
      push_point(32'h0001_0000, 0, 0, 17'h1FFFF, 0);
      push_point(100, 1, 0, 32768, 0);
      push_point(32'hFFFF_FFFF, 0, 0, 65536, 1);
      drain();
      // Poisson: zero count, zero model, equal values
      csr_write(wrcs_pkg::CSR_NOISE_MODE, 1);
      push_point(0, 32'h0003_0000, 0, 65536, 0);
      push_point(32'h0005_0000, 0, 0, 65536, 0);
      push_point(32'h0004_0000, 32'h0004_0000, 0, 40000, 0);
      push_point(32'hFFFF_FFFF, 1, 0, 65536, 0);
      push_point(1, 32'hFFFF_FFFF, 0, 1, 1);
      drain();
      // window
      csr_write(wrcs_pkg::CSR_WINDOW_START, 2);
      csr_write(wrcs_pkg::CSR_WINDOW_END, 4);
      csr_write(wrcs_pkg::CSR_WINDOW_END_ENA, 1);
      for (int i = 0; i < 6; i++) push_point(32'h0002_0000, 32'h0001_0000, 9, 65536, i == 5);
      drain();

      // receiver holds off while the sender keeps offering
      hold_rsp = 1;
      random_curves(20);
      wait (hold_cnt >= 400);
      hold_rsp = 0;
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         csr_write(wrcs_pkg::CSR_NOISE_MODE, phase[0]);
         csr_write(wrcs_pkg::CSR_USE_ERRORS, phase[1]);
         csr_write(wrcs_pkg::CSR_USE_MASK, phase[2]);
         csr_write(wrcs_pkg::CSR_WINDOW_START,
                   (phase == 3) ? 17'd65536 : 17'($urandom_range(0, 3)));
         csr_write(wrcs_pkg::CSR_WINDOW_END,
                   (phase == 5) ? 17'd0 : 17'($urandom_range(3, 30)));
         csr_write(wrcs_pkg::CSR_WINDOW_END_ENA, 17'($urandom_range(0, 1)));
         random_curves(105);
         drain();
      end
      if (errors == 0) $display("weighted_residual_chi_square_tb OK");
      else $display("weighted_residual_chi_square_tb NOT OK");
      $finish;
   end
endmodule
